### rtl/core/estimation_loss_and_gradient_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the loss and gradient unit
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef ESTIMATION_LOSS_AND_GRADIENT_MACROS_SVH
`define ESTIMATION_LOSS_AND_GRADIENT_MACROS_SVH

// property checked outside reset
`define ELG_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("loss and gradient check failed");

// property checked at every edge, reset included
`define ELG_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("loss and gradient check failed");

`endif

### rtl/core/elg_pkg.sv
// ----------------------------------------------------------------------------
// elg_pkg
// Widths, metric codes and constants of the loss and gradient unit.
// ----------------------------------------------------------------------------
`default_nettype none

package elg_pkg;

  localparam int IN_W    = 33;  // input word width
  localparam int ERR_W   = 63;  // error width
  localparam int GRAD_W  = 64;  // gradient width
  localparam int MET_W   = 3;   // metric select width
  localparam int K_W     = 6;   // log2 integer part, holds 0..IN_W
  localparam int DIV_BPS = 4;   // quotient bits per divider stage

  typedef logic [MET_W-1:0] metric_t;

  localparam metric_t MET_ABS   = 3'd0;
  localparam metric_t MET_REL   = 3'd1;
  localparam metric_t MET_QUAD  = 3'd2;
  localparam metric_t MET_LOGR  = 3'd3;
  localparam metric_t MET_SQREL = 3'd4;

  localparam logic [63:0] LN2_Q64   = 64'hB172_17F7_D1CF_79AB;
  localparam logic [63:0] ERR_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

endpackage

`default_nettype wire

### rtl/core/elg_log.sv
// ----------------------------------------------------------------------------
// elg_log
// Pipelined base-2 logarithm: top-bit index, then one fraction bit per
// squaring of a Q1.62 mantissa, two stages per bit.
// ----------------------------------------------------------------------------
`default_nettype none

module elg_log #(
  parameter int FRAC_BITS = 32
) (
  input  logic                               clk,
  input  logic [elg_pkg::IN_W:0]             x,
  output logic [elg_pkg::K_W+FRAC_BITS-1:0]  log_val
);
  import elg_pkg::*;

  localparam int M_W = 63;

  logic [K_W-1:0] k_nxt;
  logic [M_W-1:0] m_nxt;
  logic [K_W-1:0] k0_r;
  logic [M_W-1:0] m0_r;

  logic [63:0]          pll_r [FRAC_BITS];
  logic [62:0]          phl_r [FRAC_BITS];
  logic [61:0]          phh_r [FRAC_BITS];
  logic [K_W-1:0]       ka_r  [FRAC_BITS];
  logic [K_W-1:0]       kb_r  [FRAC_BITS];
  logic [FRAC_BITS-1:0] fa_r  [FRAC_BITS];
  logic [FRAC_BITS-1:0] fb_r  [FRAC_BITS];
  logic [M_W-1:0]       mb_r  [FRAC_BITS];

  // integer part and normalized mantissa
  always_comb begin
    k_nxt = '0;
    for (int i = 0; i <= IN_W; i++) begin
      if (x[i]) k_nxt = K_W'(i);
    end
    m_nxt = M_W'(x) << (6'd62 - k_nxt);
  end

  always_ff @(posedge clk) begin
    k0_r <= k_nxt;
    m0_r <= m_nxt;
  end

  // one fraction bit per pair of stages
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_sq
    logic [M_W-1:0]       m_in;
    logic [K_W-1:0]       k_in;
    logic [FRAC_BITS-1:0] f_in;
    logic [125:0]         p;
    logic [63:0]          mn;

    if (i == 0) begin : g_first
      assign m_in = m0_r;
      assign k_in = k0_r;
      assign f_in = '0;
    end else begin : g_next
      assign m_in = mb_r[i-1];
      assign k_in = kb_r[i-1];
      assign f_in = fb_r[i-1];
    end

    // partial products of the square
    always_ff @(posedge clk) begin
      pll_r[i] <= m_in[31:0] * m_in[31:0];
      phl_r[i] <= m_in[62:32] * m_in[31:0];
      phh_r[i] <= m_in[62:32] * m_in[62:32];
      ka_r[i]  <= k_in;
      fa_r[i]  <= f_in;
    end

    // sum, take Q1.62, renormalize
    assign p  = (126'(phh_r[i]) << 64) + (126'(phl_r[i]) << 33) + 126'(pll_r[i]);
    assign mn = p[125:62];

    always_ff @(posedge clk) begin
      mb_r[i] <= mn[63] ? mn[63:1] : mn[62:0];
      kb_r[i] <= ka_r[i];
      fb_r[i] <= {fa_r[i][FRAC_BITS-2:0], mn[63]};
    end
  end

  assign log_val = {kb_r[FRAC_BITS-1], fb_r[FRAC_BITS-1]};

endmodule

`default_nettype wire

### rtl/core/elg_div.sv
// ----------------------------------------------------------------------------
// elg_div
// Pipelined restoring divider, DIV_BPS quotient bits per stage. Keeps the
// low 64 quotient bits and flags any higher set bit.
// ----------------------------------------------------------------------------
`default_nettype none

module elg_div #(
  parameter int NW = 99,
  parameter int DW = 67
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [63:0]   quo,
  output logic          ovf
);
  import elg_pkg::*;

  localparam int NS  = (NW + DIV_BPS - 1) / DIV_BPS;
  localparam int NWP = NS * DIV_BPS;

  logic [NWP-1:0] n_r [NS];
  logic [DW-1:0]  d_r [NS];
  logic [DW-1:0]  r_r [NS];
  logic [63:0]    q_r [NS];
  logic           o_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [NWP-1:0] n_in, n_c;
    logic [DW-1:0]  d_in, r_in, r_c;
    logic [63:0]    q_in, q_c;
    logic           o_in, o_c;

    if (s == 0) begin : g_first
      assign n_in = NWP'(num);
      assign d_in = den;
      assign r_in = '0;
      assign q_in = '0;
      assign o_in = 1'b0;
    end else begin : g_next
      assign n_in = n_r[s-1];
      assign d_in = d_r[s-1];
      assign r_in = r_r[s-1];
      assign q_in = q_r[s-1];
      assign o_in = o_r[s-1];
    end

    // DIV_BPS shift-subtract steps
    always_comb begin
      logic [DW:0] t;
      n_c = n_in;
      r_c = r_in;
      q_c = q_in;
      o_c = o_in;
      for (int j = 0; j < DIV_BPS; j++) begin
        t   = {r_c, n_c[NWP-1]};
        n_c = n_c << 1;
        o_c = o_c | q_c[63];
        if (t >= {1'b0, d_in}) begin
          r_c = DW'(t - {1'b0, d_in});
          q_c = {q_c[62:0], 1'b1};
        end else begin
          r_c = t[DW-1:0];
          q_c = {q_c[62:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      n_r[s] <= n_c;
      d_r[s] <= d_in;
      r_r[s] <= r_c;
      q_r[s] <= q_c;
      o_r[s] <= o_c;
    end
  end

  assign quo = q_r[NS-1];
  assign ovf = o_r[NS-1];

endmodule

`default_nettype wire

### rtl/core/estimation_loss_and_gradient.sv
// ----------------------------------------------------------------------------
// estimation_loss_and_gradient
// Loss and gradient of an estimate against a true value for a selectable
// metric, saturating fixed-point outputs (unsigned error, signed gradient).
//
//   channel   ports                                  handshake
//   input     in_estimate_value, in_true_value       start, busy
//   result    out_error_value, out_gradient_value,   out_valid strobe
//             out_saturated
//   config    cfg_metric_select                      cfg_we
//
// One word enters per cycle; busy stays low.
// A word passes the input register, the squaring log pipeline, the log-difference,
// scaling, square and operand stages, the divider stages and the output register.
// Reset clears valid bits and the metric register (absolute).
// The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module estimation_loss_and_gradient #(
  parameter int FRAC_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [elg_pkg::IN_W-1:0]            in_estimate_value,
  input  logic [elg_pkg::IN_W-1:0]            in_true_value,
  input  logic                                cfg_we,
  input  elg_pkg::metric_t                    cfg_metric_select,
  output logic                                out_valid,
  output logic [elg_pkg::ERR_W-1:0]           out_error_value,
  output logic signed [elg_pkg::GRAD_W-1:0]   out_gradient_value,
  output logic                                out_saturated
);
  import elg_pkg::*;

  localparam int LOG_LAT = 1 + 2 * FRAC_BITS;
  localparam int MW      = K_W + FRAC_BITS;
  localparam int NW      = 2 * IN_W + FRAC_BITS + 1;
  localparam int DW      = 2 * IN_W + 1;
  localparam int NS      = (NW + DIV_BPS - 1) / DIV_BPS;

  function automatic logic [64:0] clip_val(input logic ovf, input logic [63:0] v,
                                           input logic [63:0] lim);
    if (ovf || (v > lim)) return {1'b1, lim};
    return {1'b0, v};
  endfunction

  metric_t metric_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= MET_ABS;
    end else if (cfg_we) begin
      metric_r <= cfg_metric_select;
    end
  end

  assign busy = 1'b0;

  // input stage
  logic            v0_r;
  metric_t         met0_r;
  logic [IN_W-1:0] e0_r, t0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
    met0_r <= metric_r;
    e0_r   <= in_estimate_value;
    t0_r   <= in_true_value;
  end

  // logarithms of t+1 and e+1
  logic [MW-1:0] lt, le;

  elg_log #(.FRAC_BITS(FRAC_BITS)) u_log_t (
    .clk(clk), .x({1'b0, t0_r} + (IN_W+1)'(1)), .log_val(lt)
  );
  elg_log #(.FRAC_BITS(FRAC_BITS)) u_log_e (
    .clk(clk), .x({1'b0, e0_r} + (IN_W+1)'(1)), .log_val(le)
  );

  // side words alongside the log pipeline
  logic            sl_v   [LOG_LAT];
  metric_t         sl_met [LOG_LAT];
  logic [IN_W-1:0] sl_e   [LOG_LAT];
  logic [IN_W-1:0] sl_t   [LOG_LAT];
  logic [IN_W-1:0] sl_d   [LOG_LAT];
  logic            sl_gt  [LOG_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LOG_LAT; i++) sl_v[i] <= 1'b0;
    end else begin
      sl_v[0] <= v0_r;
      for (int i = 1; i < LOG_LAT; i++) sl_v[i] <= sl_v[i-1];
    end
    sl_met[0] <= met0_r;
    sl_e[0]   <= e0_r;
    sl_t[0]   <= t0_r;
    sl_d[0]   <= (t0_r > e0_r) ? t0_r - e0_r : e0_r - t0_r;
    sl_gt[0]  <= (t0_r > e0_r);
    for (int i = 1; i < LOG_LAT; i++) begin
      sl_met[i] <= sl_met[i-1];
      sl_e[i]   <= sl_e[i-1];
      sl_t[i]   <= sl_t[i-1];
      sl_d[i]   <= sl_d[i-1];
      sl_gt[i]  <= sl_gt[i-1];
    end
  end

  // stages 1..4: log difference, ln2 scaling, squares
  logic              v1_r, v2_r, v3_r, v4_r;
  metric_t           met1_r, met2_r, met3_r, met4_r;
  logic [IN_W-1:0]   e1_r, e2_r, e3_r, e4_r;
  logic [IN_W-1:0]   t1_r, t2_r, t3_r, t4_r;
  logic [IN_W-1:0]   d1_r, d2_r, d3_r, d4_r;
  logic              gt1_r, gt2_r, gt3_r, gt4_r;
  logic              lneg1_r, lneg2_r, lneg3_r, lneg4_r;
  logic [2*IN_W-1:0] dsq1_r, dsq2_r, dsq3_r, dsq4_r;
  logic [DW-1:0]     tsq1_r, tsq2_r, tsq3_r, tsq4_r;
  logic [MW-1:0]     m1_r;
  logic [MW+31:0]    pl2_r, ph2_r;
  logic [MW+32:0]    lsum;
  logic [MW-1:0]     ld3_r, ld4_r;
  logic [2*MW-1:0]   ldsq4_r;
  logic [IN_W:0]     tp1_s1;

  assign tp1_s1 = {1'b0, sl_t[LOG_LAT-1]} + (IN_W+1)'(1);
  assign lsum   = (MW+33)'(ph2_r) + (MW+33)'(pl2_r >> 32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= sl_v[LOG_LAT-1];
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    // stage 1
    met1_r  <= sl_met[LOG_LAT-1];
    e1_r    <= sl_e[LOG_LAT-1];
    t1_r    <= sl_t[LOG_LAT-1];
    d1_r    <= sl_d[LOG_LAT-1];
    gt1_r   <= sl_gt[LOG_LAT-1];
    m1_r    <= (lt >= le) ? lt - le : le - lt;
    lneg1_r <= (lt > le);
    dsq1_r  <= sl_d[LOG_LAT-1] * sl_d[LOG_LAT-1];
    tsq1_r  <= DW'(tp1_s1) * DW'(tp1_s1);
    // stage 2
    met2_r  <= met1_r;  e2_r <= e1_r;  t2_r <= t1_r;  d2_r <= d1_r;
    gt2_r   <= gt1_r;   lneg2_r <= lneg1_r;
    dsq2_r  <= dsq1_r;  tsq2_r <= tsq1_r;
    pl2_r   <= m1_r * LN2_Q64[31:0];
    ph2_r   <= m1_r * LN2_Q64[63:32];
    // stage 3
    met3_r  <= met2_r;  e3_r <= e2_r;  t3_r <= t2_r;  d3_r <= d2_r;
    gt3_r   <= gt2_r;   lneg3_r <= lneg2_r;
    dsq3_r  <= dsq2_r;  tsq3_r <= tsq2_r;
    ld3_r   <= lsum[MW+31:32];
    // stage 4
    met4_r  <= met3_r;  e4_r <= e3_r;  t4_r <= t3_r;  d4_r <= d3_r;
    gt4_r   <= gt3_r;   lneg4_r <= lneg3_r;
    dsq4_r  <= dsq3_r;  tsq4_r <= tsq3_r;
    ld4_r   <= ld3_r;
    ldsq4_r <= ld3_r * ld3_r;
  end

  // stage 5: operands per metric
  logic [NW-1:0] na_nxt, nb_nxt;
  logic [DW-1:0] da_nxt, db_nxt;
  logic [63:0]   ed_nxt, gd_nxt;
  logic          neg_nxt;

  always_comb begin
    na_nxt  = '0;
    nb_nxt  = '0;
    da_nxt  = DW'(1);
    db_nxt  = DW'(1);
    ed_nxt  = '0;
    gd_nxt  = '0;
    neg_nxt = 1'b0;
    case (met4_r)
      MET_ABS: begin
        ed_nxt  = 64'(d4_r);
        gd_nxt  = (d4_r != '0) ? (64'(1) << FRAC_BITS) : '0;
        neg_nxt = gt4_r;
      end
      MET_REL: begin
        na_nxt  = NW'(d4_r) << FRAC_BITS;
        da_nxt  = DW'(t4_r) + DW'(1);
        nb_nxt  = (d4_r != '0) ? (NW'(1) << (2 * FRAC_BITS)) : '0;
        db_nxt  = DW'(t4_r) + DW'(1);
        neg_nxt = gt4_r;
      end
      MET_QUAD: begin
        ed_nxt  = 64'(dsq4_r >> FRAC_BITS);
        gd_nxt  = 64'(d4_r) << 1;
        neg_nxt = gt4_r;
      end
      MET_LOGR: begin
        ed_nxt  = 64'(ldsq4_r >> FRAC_BITS);
        nb_nxt  = NW'(ld4_r) << (FRAC_BITS + 1);
        db_nxt  = DW'(e4_r) + DW'(1);
        neg_nxt = lneg4_r;
      end
      MET_SQREL: begin
        na_nxt  = NW'(dsq4_r) << FRAC_BITS;
        da_nxt  = tsq4_r;
        nb_nxt  = NW'(d4_r) << (2 * FRAC_BITS + 1);
        db_nxt  = tsq4_r;
        neg_nxt = gt4_r;
      end
      default: begin
        neg_nxt = 1'b0;
      end
    endcase
  end

  logic          v5_r, neg5_r;
  metric_t       met5_r;
  logic [NW-1:0] na5_r, nb5_r;
  logic [DW-1:0] da5_r, db5_r;
  logic [63:0]   ed5_r, gd5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    met5_r <= met4_r;
    neg5_r <= neg_nxt;
    na5_r  <= na_nxt;
    nb5_r  <= nb_nxt;
    da5_r  <= da_nxt;
    db5_r  <= db_nxt;
    ed5_r  <= ed_nxt;
    gd5_r  <= gd_nxt;
  end

  // dividers: lane a error, lane b gradient
  logic [63:0] qa, qb;
  logic        oa, ob;

  elg_div #(.NW(NW), .DW(DW)) u_div_a (
    .clk(clk), .num(na5_r), .den(da5_r), .quo(qa), .ovf(oa)
  );
  elg_div #(.NW(NW), .DW(DW)) u_div_b (
    .clk(clk), .num(nb5_r), .den(db5_r), .quo(qb), .ovf(ob)
  );

  // side words alongside the dividers
  logic        sd_v   [NS];
  metric_t     sd_met [NS];
  logic        sd_neg [NS];
  logic [63:0] sd_ed  [NS];
  logic [63:0] sd_gd  [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) sd_v[i] <= 1'b0;
    end else begin
      sd_v[0] <= v5_r;
      for (int i = 1; i < NS; i++) sd_v[i] <= sd_v[i-1];
    end
    sd_met[0] <= met5_r;
    sd_neg[0] <= neg5_r;
    sd_ed[0]  <= ed5_r;
    sd_gd[0]  <= gd5_r;
    for (int i = 1; i < NS; i++) begin
      sd_met[i] <= sd_met[i-1];
      sd_neg[i] <= sd_neg[i-1];
      sd_ed[i]  <= sd_ed[i-1];
      sd_gd[i]  <= sd_gd[i-1];
    end
  end

  // final select, clip and sign
  logic [64:0] ec, gc;
  logic [63:0] ev, gv;
  logic        eo, go;
  logic        fneg;

  always_comb begin
    fneg = sd_neg[NS-1];
    case (sd_met[NS-1])
      MET_ABS, MET_QUAD: begin
        ev = sd_ed[NS-1]; eo = 1'b0;
        gv = sd_gd[NS-1]; go = 1'b0;
      end
      MET_REL, MET_SQREL: begin
        ev = qa; eo = oa;
        gv = qb; go = ob;
      end
      MET_LOGR: begin
        ev = sd_ed[NS-1]; eo = 1'b0;
        gv = qb; go = ob;
      end
      default: begin
        ev = '0; eo = 1'b0;
        gv = '0; go = 1'b0;
      end
    endcase
    ec = clip_val(eo, ev, ERR_MAX);
    gc = clip_val(go, gv, fneg ? NEG_LIMIT : ERR_MAX);
  end

  logic                     out_valid_r, out_sat_r;
  logic [ERR_W-1:0]         out_err_r;
  logic signed [GRAD_W-1:0] out_grad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sd_v[NS-1];
    end
    out_err_r  <= ec[ERR_W-1:0];
    out_grad_r <= fneg ? GRAD_W'(64'd0 - gc[63:0]) : gc[63:0];
    out_sat_r  <= ec[64] | gc[64];
  end

  assign out_valid          = out_valid_r;
  assign out_error_value    = out_err_r;
  assign out_gradient_value = out_grad_r;
  assign out_saturated      = out_sat_r;

endmodule

`default_nettype wire

### rtl/core/elg_chk.sv
// ----------------------------------------------------------------------------
// elg_chk
// Port-level checks of the loss and gradient unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "estimation_loss_and_gradient_macros.svh"

module elg_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               out_valid,
  input wire logic [elg_pkg::ERR_W-1:0]          out_error_value,
  input wire logic signed [elg_pkg::GRAD_W-1:0]  out_gradient_value,
  input wire logic                               out_saturated
);
  import elg_pkg::*;

  // some output sits at one of its limits
  logic at_limit;

  assign at_limit = (out_error_value == ERR_MAX[ERR_W-1:0]) ||
                    (out_gradient_value == ERR_MAX) ||
                    (out_gradient_value == NEG_LIMIT);

  // pipeline takes a word every cycle
  `ELG_ASSERT(a_never_busy, clk, rst_n, start |-> !busy)

  // a clipped result sits at one of its limits
  `ELG_ASSERT(a_sat_at_limit, clk, rst_n, (out_valid && out_saturated) |-> at_limit)

  // no result strobe right after a reset cycle
  `ELG_ASSERT_ALWAYS(a_quiet_after_reset, clk, $past(!rst_n) |-> !out_valid)

endmodule

bind estimation_loss_and_gradient elg_chk u_elg_chk (.*);

`default_nettype wire

### bench/elg_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elg_scoreboard
// Watches the input, result and config ports of the loss and gradient unit,
// predicts each result word from the accepted input word and compares them.
// ----------------------------------------------------------------------------
module elg_scoreboard (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [elg_pkg::IN_W-1:0]          in_estimate_value,
  input  logic [elg_pkg::IN_W-1:0]          in_true_value,
  input  logic                              cfg_we,
  input  elg_pkg::metric_t                  cfg_metric_select,
  input  logic                              out_valid,
  input  logic [elg_pkg::ERR_W-1:0]         out_error_value,
  input  logic signed [elg_pkg::GRAD_W-1:0] out_gradient_value,
  input  logic                              out_saturated,
  output int                                fail_count,
  output int                                pending
);
  import elg_pkg::*;

  typedef struct packed {
    logic [ERR_W-1:0]  err;
    logic [GRAD_W-1:0] grad;
    logic              sat;
  } loss_word_t;

  localparam int FB = 32;

  metric_t    metric_q;
  loss_word_t loss_fifo[$];

  // log2 with FB fraction bits, truncated, by repeated squaring
  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int          k;
    logic [63:0] m;
    logic [63:0] frac;
    logic [127:0] p;
    k = 0;
    frac = '0;
    for (int i = 0; i < 64; i++) if (x[i]) k = i;
    m = x << (62 - k);
    for (int i = 0; i < FB; i++) begin
      p = {64'd0, m} * {64'd0, m};
      m = p[125:62];
      frac = frac << 1;
      if (m >= NEG_LIMIT) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(k) << FB) | frac;
  endfunction

  function automatic logic [63:0] sat_to(logic [127:0] v, logic [63:0] lim, ref logic flag);
    if (v > {64'd0, lim}) begin
      flag = 1'b1;
      return lim;
    end
    return v[63:0];
  endfunction

  // expected loss word for one input word under metric m
  function automatic loss_word_t predict_loss(metric_t m, logic [IN_W-1:0] e_in,
                                              logic [IN_W-1:0] t_in);
    logic [127:0] e, t, d, den, ev, gv, la, lb, lm, dl;
    logic         neg, sat;
    logic [63:0]  err, g;
    loss_word_t   r;
    e = 128'(e_in);
    t = 128'(t_in);
    d = (t > e) ? t - e : e - t;
    den = t + 1;
    neg = (t > e);
    sat = 1'b0;
    ev = '0;
    gv = '0;
    case (m)
      MET_ABS: begin
        ev = d;
        gv = (d != 0) ? (128'd1 << FB) : '0;
      end
      MET_REL: begin
        ev = (d << FB) / den;
        gv = (d != 0) ? (128'd1 << (2 * FB)) / den : '0;
      end
      MET_QUAD: begin
        ev = (d * d) >> FB;
        gv = d << 1;
      end
      MET_LOGR: begin
        la = 128'(log2_fix(64'(t_in) + 1));
        lb = 128'(log2_fix(64'(e_in) + 1));
        if (la >= lb) begin
          lm = la - lb;
          neg = (lm != 0);
        end else begin
          lm = lb - la;
          neg = 1'b0;
        end
        dl = (lm * 128'(LN2_Q64)) >> 64;
        ev = (dl * dl) >> FB;
        gv = (dl << (FB + 1)) / (e + 1);
      end
      MET_SQREL: begin
        ev = ((d * d) << FB) / den / den;
        gv = (d != 0) ? (d << (2 * FB + 1)) / den / den : '0;
      end
      default: neg = 1'b0;
    endcase
    err = sat_to(ev, ERR_MAX, sat);
    g = sat_to(gv, neg ? NEG_LIMIT : ERR_MAX, sat);
    r.err = err[ERR_W-1:0];
    r.grad = neg ? 64'd0 - g : g;
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = loss_fifo.size();

  initial fail_count = 0;

  // track config, predict on accept, compare on result strobe
  always @(posedge clk) begin
    loss_word_t w;
    if (!rst_n) begin
      metric_q <= MET_ABS;
    end else begin
      if (cfg_we) metric_q <= cfg_metric_select;
      if (start && !busy)
        loss_fifo.push_back(predict_loss(metric_q, in_estimate_value, in_true_value));
      if (out_valid) begin
        if (loss_fifo.size() == 0) begin
          report_mismatch("unexpected word", {1'b0, out_error_value}, '0);
        end else begin
          w = loss_fifo.pop_front();
          if (out_error_value !== w.err)
            report_mismatch("error_value", {1'b0, out_error_value}, {1'b0, w.err});
          if (out_gradient_value !== w.grad)
            report_mismatch("gradient_value", out_gradient_value, w.grad);
          if (out_saturated !== w.sat)
            report_mismatch("saturated", 64'(out_saturated), 64'(w.sat));
        end
      end
    end
  end

endmodule

### bench/estimation_loss_and_gradient_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// estimation_loss_and_gradient_tb
// Drives directed and random estimate/true words through every metric
// setting with random start gaps; a scoreboard checks each result word.
// ----------------------------------------------------------------------------
module estimation_loss_and_gradient_tb;
  import elg_pkg::*;

  localparam metric_t MET_UNUSED_LO = 3'd5;
  localparam metric_t MET_UNUSED_HI = 3'd7;
  localparam logic [IN_W-1:0] IN_MAX = {IN_W{1'b1}};
  localparam logic [IN_W-1:0] ONE_FX = 33'h1_0000_0000;
  localparam int DRAIN_CYC = 120;
  localparam int STALL_LIMIT = 4000;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [IN_W-1:0]            in_estimate_value;
  logic [IN_W-1:0]            in_true_value;
  logic                       cfg_we;
  metric_t                    cfg_metric_select;
  logic                       out_valid;
  logic [ERR_W-1:0]           out_error_value;
  logic signed [GRAD_W-1:0]   out_gradient_value;
  logic                       out_saturated;
  int                         fail_count;
  int                         pending;
  int                         stall_cnt;
  int                         words_sent;
  int                         idle_pct;

  estimation_loss_and_gradient uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_estimate_value(in_estimate_value), .in_true_value(in_true_value),
    .cfg_we(cfg_we), .cfg_metric_select(cfg_metric_select),
    .out_valid(out_valid), .out_error_value(out_error_value),
    .out_gradient_value(out_gradient_value), .out_saturated(out_saturated)
  );

  elg_scoreboard sb (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_estimate_value(in_estimate_value), .in_true_value(in_true_value),
    .cfg_we(cfg_we), .cfg_metric_select(cfg_metric_select),
    .out_valid(out_valid), .out_error_value(out_error_value),
    .out_gradient_value(out_gradient_value), .out_saturated(out_saturated),
    .fail_count(fail_count), .pending(pending)
  );

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // watchdog on cycles with no accepted word and no result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog timeout");
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one input word, with random idle cycles ahead of it
  task automatic send_word(logic [IN_W-1:0] e, logic [IN_W-1:0] t);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_estimate_value <= e;
    in_true_value <= t;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // drain results, then write the metric register while idle
  task automatic set_metric(metric_t m);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_metric_select <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [IN_W-1:0] rand_value();
    logic [IN_W-1:0] v;
    v = IN_W'({$urandom(), $urandom()});
    case ($urandom_range(5, 0))
      0: return v;
      1: return v & 33'hFFFF;
      2: return ONE_FX + 33'($signed(12'($urandom())));
      3: return v >> $urandom_range(32, 0);
      4: return IN_MAX - (v & 33'hFF);
      default: return v & 33'h0_FFFF_FFFF;
    endcase
  endfunction

  initial begin
    metric_t m;
    logic [IN_W-1:0] e, t;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_metric_select = MET_ABS;
    in_estimate_value = '0;
    in_true_value = '0;
    stall_cnt = 0;
    words_sent = 0;
    idle_pct = 14;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes and equal inputs under every setting, reset value first
    for (int s = 0; s < 8; s++) begin
      if (s != 0) set_metric(metric_t'(s));
      send_word('0, IN_MAX);
      send_word(IN_MAX, '0);
      send_word(ONE_FX, ONE_FX);
    end

    // random phases; one runs with no idling
    for (int ph = 0; ph < 13; ph++) begin
      if (ph == 0) m = MET_UNUSED_HI;
      else if (ph == 1) m = MET_UNUSED_LO;
      else if (ph < 7) m = metric_t'(ph - 2);
      else m = metric_t'($urandom_range(4, 0));
      set_metric(m);
      idle_pct = (ph == 8) ? 0 : 14;
      for (int i = 0; i < 150; i++) begin
        e = rand_value();
        t = ($urandom_range(9, 0) == 0) ? e : rand_value();
        send_word(e, t);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("Sent %0d words over all eight metric settings, extremes and equal inputs",
             words_sent);
    $display("included, with random start gaps and one gap-free phase.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/elg_pkg.sv
rtl/core/elg_log.sv
rtl/core/elg_div.sv
rtl/core/estimation_loss_and_gradient.sv
rtl/core/elg_chk.sv
bench/elg_scoreboard.sv
bench/estimation_loss_and_gradient_tb.sv
